// ===== src/smk_pkg.sv =====
// Shared widths, register codes, reset values and the arctangent table
// for the swerve module kinematics pipeline. No dependencies.
`default_nettype none

package smk_pkg;

    // Field widths of the streams and registers
    localparam int IN_W   = 13;
    localparam int LEN_W  = 10;
    localparam int LIM_W  = 13;
    localparam int ANG_W  = 16;
    localparam int SPD_W  = 13;
    localparam int IN_TDATA_W  = 40;
    localparam int WHEEL_FLD_W = ANG_W + SPD_W;
    localparam int OUT_TDATA_W = 120;
    localparam int NUM_WHEELS  = 4;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_ADDR_W-1:0] REG_WHEEL_BASE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WHEEL_TRACK = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_LIMIT = 2'd2;
    localparam logic [LEN_W-1:0] WHEEL_BASE_RST  = 10'd154;
    localparam logic [LEN_W-1:0] WHEEL_TRACK_RST = 10'd154;
    localparam logic [LIM_W-1:0] SPEED_LIMIT_RST = 13'd1024;

    // Internal datapath widths
    localparam int VX_W    = 14;  // negated strafe
    localparam int VEL_W   = 24;  // a, b, c, d in 2^-17 m/s
    localparam int SQ_W    = 46;
    localparam int RAD_W   = 50;
    localparam int ROOT_W  = 25;
    localparam int REM_W   = 27;
    localparam int RAW_W   = 16;  // raw speed before normalization
    localparam int XY_W    = 34;
    localparam int Z_W     = 27;
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 25;
    localparam int DIV_STEPS    = 14;
    localparam int NUM_W   = 31;
    localparam int DEN_W   = 17;

    // Register levels inside one wheel unit, and of the whole datapath
    localparam int WHEEL_LAT  = 28;
    localparam int PIPE_DEPTH = 2 + WHEEL_LAT + 2 + DIV_STEPS;

    // Angle constants
    localparam int ANG_LIM   = 18000;
    localparam int ANG_QTR   = 9000;
    localparam int HALF_TURN = 18432000;  // 180 degrees in 1/102400 degree
    localparam int Z_RND     = 512;

    typedef struct packed {
        logic signed [ANG_W-1:0] angle;
        logic [RAW_W-1:0]        speed;
    } wheel_res_t;

    function automatic logic signed [Z_W-1:0] atan_step(input logic [3:0] idx);
        case (idx)
            4'd0:    return Z_W'(4608000);
            4'd1:    return Z_W'(2720261);
            4'd2:    return Z_W'(1437311);
            4'd3:    return Z_W'(729602);
            4'd4:    return Z_W'(366217);
            4'd5:    return Z_W'(183287);
            4'd6:    return Z_W'(91666);
            4'd7:    return Z_W'(45836);
            4'd8:    return Z_W'(22918);
            4'd9:    return Z_W'(11459);
            4'd10:   return Z_W'(5730);
            4'd11:   return Z_W'(2865);
            4'd12:   return Z_W'(1432);
            4'd13:   return Z_W'(716);
            4'd14:   return Z_W'(358);
            default: return Z_W'(179);
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== src/smk_wheel.sv =====
// One wheel unit: steering angle by pipelined CORDIC vectoring and raw speed
// by a pipelined digit-by-digit square root. Depends on smk_pkg.
`default_nettype none

module smk_wheel import smk_pkg::*; (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [VEL_W-1:0] p,
    input  logic signed [VEL_W-1:0] q,
    output wheel_res_t              res
);

    localparam int ANG_DLY = WHEEL_LAT - CORDIC_STEPS - 2;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   p_zero;
        logic                   q_zero;
        logic                   p_pos;
        logic                   q_neg;
    } cordic_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    // Stage 0: squares and CORDIC prerotation
    logic signed [VEL_W-1:0] p_neg, q_neg;
    logic [VEL_W-2:0]        p_mag, q_mag;
    logic [SQ_W-1:0]         psq_reg, qsq_reg, psq_next, qsq_next;
    cordic_t                 cs_reg [CORDIC_STEPS+1];
    cordic_t                 cs0_next;
    logic signed [XY_W-1:0]  x_sh, y_sh;

    assign p_neg = -p;
    assign q_neg = -q;
    assign p_mag = p[VEL_W-1] ? p_neg[VEL_W-2:0] : p[VEL_W-2:0];
    assign q_mag = q[VEL_W-1] ? q_neg[VEL_W-2:0] : q[VEL_W-2:0];
    assign psq_next = SQ_W'(p_mag) * SQ_W'(p_mag);
    assign qsq_next = SQ_W'(q_mag) * SQ_W'(q_mag);
    assign x_sh = XY_W'(q) <<< 8;
    assign y_sh = XY_W'(p) <<< 8;

    always_comb begin
        cs0_next.p_zero = (p == '0);
        cs0_next.q_zero = (q == '0);
        cs0_next.p_pos  = !p[VEL_W-1] && (p != '0);
        cs0_next.q_neg  = q[VEL_W-1];
        if (q[VEL_W-1]) begin
            // left half plane: rotate by 180 degrees first
            cs0_next.x = -x_sh;
            cs0_next.y = -y_sh;
            cs0_next.z = p[VEL_W-1] ? -Z_W'(HALF_TURN) : Z_W'(HALF_TURN);
        end else begin
            cs0_next.x = x_sh;
            cs0_next.y = y_sh;
            cs0_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            psq_reg   <= psq_next;
            qsq_reg   <= qsq_next;
            cs_reg[0] <= cs0_next;
        end
    end

    // CORDIC vectoring, one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        cordic_t                cs_next;
        logic signed [XY_W-1:0] xs, ys;
        assign xs = cs_reg[i].x >>> i;
        assign ys = cs_reg[i].y >>> i;
        always_comb begin
            cs_next = cs_reg[i];
            if (!cs_reg[i].y[XY_W-1] && (cs_reg[i].y != '0)) begin
                cs_next.x = cs_reg[i].x + ys;
                cs_next.y = cs_reg[i].y - xs;
                cs_next.z = cs_reg[i].z + atan_step(4'(i));
            end else begin
                cs_next.x = cs_reg[i].x - ys;
                cs_next.y = cs_reg[i].y + xs;
                cs_next.z = cs_reg[i].z - atan_step(4'(i));
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                cs_reg[i+1] <= cs_next;
            end
        end
    end

    // Round to hundredths, clamp, negate, and patch the axis cases
    cordic_t                 cs_last;
    logic signed [Z_W-1:0]   z_rnd;
    logic signed [Z_W-11:0]  h;
    logic signed [ANG_W-1:0] h_clamp;
    logic signed [ANG_W-1:0] ang_next;
    logic signed [ANG_W-1:0] ang_reg [ANG_DLY+1];

    assign cs_last = cs_reg[CORDIC_STEPS];
    assign z_rnd   = cs_last.z + Z_W'(Z_RND);
    assign h       = $signed(z_rnd[Z_W-1:10]);

    always_comb begin
        if (h > ANG_LIM) begin
            h_clamp = ANG_W'(ANG_LIM);
        end else if (h < -ANG_LIM) begin
            h_clamp = -ANG_W'(ANG_LIM);
        end else begin
            h_clamp = h[ANG_W-1:0];
        end
        if (cs_last.p_zero) begin
            ang_next = cs_last.q_neg ? -ANG_W'(ANG_LIM) : '0;
        end else if (cs_last.q_zero) begin
            ang_next = cs_last.p_pos ? -ANG_W'(ANG_QTR) : ANG_W'(ANG_QTR);
        end else begin
            ang_next = -h_clamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg[0] <= ang_next;
        end
    end

    // Hold the angle until the square root catches up
    for (genvar k = 0; k < ANG_DLY; k++) begin : g_ang_dly
        always_ff @(posedge aclk) begin
            if (en) begin
                ang_reg[k+1] <= ang_reg[k];
            end
        end
    end

    // Square root of 4*(p*p + q*q), two radicand bits per stage
    sqrt_t             sq_reg [SQRT_STEPS+1];
    logic [SQ_W:0]     sum_sq;
    logic [ROOT_W:0]   root_rnd;
    logic [RAW_W-1:0]  speed_reg;

    assign sum_sq = (SQ_W+1)'(psq_reg) + (SQ_W+1)'(qsq_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg[0].rad  <= RAD_W'({sum_sq, 2'b00});
            sq_reg[0].rem  <= '0;
            sq_reg[0].root <= '0;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        logic [REM_W+1:0] rem_ext;
        logic [REM_W+1:0] trial;
        sqrt_t            sq_next;
        assign rem_ext = {sq_reg[j].rem, sq_reg[j].rad[RAD_W-1-2*j -: 2]};
        assign trial   = (REM_W+2)'({sq_reg[j].root, 2'b01});
        always_comb begin
            sq_next.rad = sq_reg[j].rad;
            if (rem_ext >= trial) begin
                sq_next.rem  = REM_W'(rem_ext - trial);
                sq_next.root = {sq_reg[j].root[ROOT_W-2:0], 1'b1};
            end else begin
                sq_next.rem  = rem_ext[REM_W-1:0];
                sq_next.root = {sq_reg[j].root[ROOT_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                sq_reg[j+1] <= sq_next;
            end
        end
    end

    assign root_rnd = (ROOT_W+1)'(sq_reg[SQRT_STEPS].root) + (ROOT_W+1)'(512);

    always_ff @(posedge aclk) begin
        if (en) begin
            speed_reg <= root_rnd[ROOT_W:10];
        end
    end

    assign res.angle = ang_reg[ANG_DLY];
    assign res.speed = speed_reg;

endmodule

`default_nettype wire

// ===== src/swerve_module_kinematics.sv =====
// Four-wheel swerve inverse kinematics, top level: input stages, four wheel
// units, speed normalization by pipelined division. Depends on smk_pkg, smk_wheel.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one chassis command per transaction;
//   m_tvalid/m_tready/m_tdata carry the four wheel angles and speeds.
//   cfg_we/cfg_addr/cfg_wdata write wheel_base (0), wheel_track (1) and
//   speed_limit (2); write them only while no command is in flight.
// Pipeline: it includes the 25-stage square root inside each wheel unit and
//   the 14-stage divider.
// Throughput: one command per cycle unless the output stalls; all stages pipelined.
// Stall: while m_tvalid is high and m_tready low, the pipeline keeps
//   advancing into empty stages; it holds only once its last stage is
//   full, and then drops s_tready. Nothing is lost or repeated.
// Reset: aresetn (synchronous, active low) empties the pipeline, drops
//   m_tvalid and loads the registers with 154, 154 and 1024.
`default_nettype none

module swerve_module_kinematics import smk_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // forward_speed[12:0], strafe_speed[25:13], turn_rate[38:26], pad[39]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // front_left_angle[15:0], front_left_speed[28:16],
    // front_right_angle[44:29], front_right_speed[57:45],
    // back_left_angle[73:58], back_left_speed[86:74],
    // back_right_angle[102:87], back_right_speed[115:103], pad[119:116]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    typedef struct packed {
        logic [NUM_WHEELS-1:0][NUM_W-1:0]     rem;
        logic [NUM_WHEELS-1:0][DIV_STEPS-1:0] quo;
        logic [DEN_W-1:0]                     den;
        logic                                 scale;
        wheel_res_t [NUM_WHEELS-1:0]          res;
    } div_t;

    // Configuration registers
    logic [LEN_W-1:0] wheel_base_reg, wheel_track_reg;
    logic [LIM_W-1:0] speed_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_base_reg  <= WHEEL_BASE_RST;
            wheel_track_reg <= WHEEL_TRACK_RST;
            speed_limit_reg <= SPEED_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_WHEEL_BASE:  wheel_base_reg  <= cfg_wdata[LEN_W-1:0];
                REG_WHEEL_TRACK: wheel_track_reg <= cfg_wdata[LEN_W-1:0];
                REG_SPEED_LIMIT: speed_limit_reg <= cfg_wdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Flow control: advance unless the last stage is full and the output stalls
    logic                  adv;
    logic [PIPE_DEPTH-1:0] v_reg;
    logic                  m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, out_data;

    assign adv      = !v_reg[PIPE_DEPTH-1] || !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // Stage A: negate strafe, scale turn rate by the spacings
    logic signed [IN_W-1:0]  fwd_in, strafe_in, turn_in;
    logic signed [VX_W-1:0]  vx_reg;
    logic signed [IN_W-1:0]  vy_reg;
    logic signed [VEL_W-1:0] wl_reg, ww_reg;

    assign fwd_in    = $signed(s_tdata[IN_W-1:0]);
    assign strafe_in = $signed(s_tdata[2*IN_W-1:IN_W]);
    assign turn_in   = $signed(s_tdata[3*IN_W-1:2*IN_W]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            vx_reg <= -VX_W'(strafe_in);
            vy_reg <= fwd_in;
            wl_reg <= VEL_W'(turn_in) * VEL_W'($signed({1'b0, wheel_base_reg}));
            ww_reg <= VEL_W'(turn_in) * VEL_W'($signed({1'b0, wheel_track_reg}));
        end
    end

    // Stage B: a, b, c, d
    logic signed [VEL_W-1:0] vx_sh, vy_sh;
    logic signed [VEL_W-1:0] a_reg, b_reg, c_reg, d_reg;

    assign vx_sh = VEL_W'(vx_reg) <<< 9;
    assign vy_sh = VEL_W'(vy_reg) <<< 9;

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg <= vx_sh - wl_reg;
            b_reg <= vx_sh + wl_reg;
            c_reg <= vy_sh - ww_reg;
            d_reg <= vy_sh + ww_reg;
        end
    end

    // Wheel units: front left, front right, back left, back right
    wheel_res_t [NUM_WHEELS-1:0] wres;

    smk_wheel u_wheel_fl (.aclk(aclk), .en(adv), .p(b_reg), .q(d_reg), .res(wres[0]));
    smk_wheel u_wheel_fr (.aclk(aclk), .en(adv), .p(b_reg), .q(c_reg), .res(wres[1]));
    smk_wheel u_wheel_bl (.aclk(aclk), .en(adv), .p(a_reg), .q(d_reg), .res(wres[2]));
    smk_wheel u_wheel_br (.aclk(aclk), .en(adv), .p(a_reg), .q(c_reg), .res(wres[3]));

    // Stage M1: largest raw speed
    logic [RAW_W-1:0]            mx01, mx23, top_next, top_reg;
    wheel_res_t [NUM_WHEELS-1:0] m1_res_reg;

    assign mx01     = (wres[0].speed > wres[1].speed) ? wres[0].speed : wres[1].speed;
    assign mx23     = (wres[2].speed > wres[3].speed) ? wres[2].speed : wres[3].speed;
    assign top_next = (mx01 > mx23) ? mx01 : mx23;

    always_ff @(posedge aclk) begin
        if (adv) begin
            top_reg    <= top_next;
            m1_res_reg <= wres;
        end
    end

    // Stage M2: numerators 2*speed*limit + top over denominator 2*top
    div_t dv_reg [DIV_STEPS+1];
    div_t dv0_next;

    always_comb begin
        dv0_next.den   = {top_reg, 1'b0};
        dv0_next.scale = (top_reg > RAW_W'(speed_limit_reg));
        dv0_next.res   = m1_res_reg;
        dv0_next.quo   = '0;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            dv0_next.rem[k] =
                NUM_W'({NUM_W'(m1_res_reg[k].speed) * NUM_W'(speed_limit_reg), 1'b0})
                + NUM_W'(top_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_reg[0] <= dv0_next;
        end
    end

    // Restoring division, one quotient bit per stage, MSB first
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        localparam int QB = DIV_STEPS - 1 - s;
        logic [NUM_W-1:0] dsh;
        div_t             dv_next;
        assign dsh = NUM_W'(dv_reg[s].den) << QB;
        always_comb begin
            dv_next = dv_reg[s];
            for (int k = 0; k < NUM_WHEELS; k++) begin
                if (dv_reg[s].rem[k] >= dsh) begin
                    dv_next.rem[k]     = dv_reg[s].rem[k] - dsh;
                    dv_next.quo[k][QB] = 1'b1;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_reg[s+1] <= dv_next;
            end
        end
    end

    // Output packing and register
    div_t dv_last;
    assign dv_last = dv_reg[DIV_STEPS];

    always_comb begin
        out_data = '0;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            out_data[k*WHEEL_FLD_W +: ANG_W] = dv_last.res[k].angle;
            out_data[k*WHEEL_FLD_W + ANG_W +: SPD_W] =
                dv_last.scale ? dv_last.quo[k][SPD_W-1:0]
                              : dv_last.res[k].speed[SPD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            m_tvalid_reg <= v_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || m_tready) begin
            m_tdata_reg <= out_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // An empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid_reg |-> s_tready)
        else $error("input blocked with empty output register");

    // A finished transaction reaches the output register when it has room
    a_last_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[PIPE_DEPTH-1] && (!m_tvalid_reg || m_tready)) |=> m_tvalid_reg)
        else $error("finished transaction dropped at output");

    // Front left and back right angles stay within half a turn
    a_fl_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ($signed(m_tdata_reg[ANG_W-1:0]) <= ANG_LIM)
                      && ($signed(m_tdata_reg[ANG_W-1:0]) >= -ANG_LIM))
        else $error("front left angle out of range");

    a_br_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ($signed(m_tdata_reg[3*WHEEL_FLD_W +: ANG_W]) <= ANG_LIM)
                      && ($signed(m_tdata_reg[3*WHEEL_FLD_W +: ANG_W]) >= -ANG_LIM))
        else $error("back right angle out of range");
`endif

endmodule

`default_nettype wire
